// File: rtl/grb_pkg.sv
// Shared types and constants for the group reverse buffer.
`timescale 1ns / 1ps

package grb_pkg;

    // Count field width covers group sizes up to 127 values
    localparam int CNT_W = 7;

    // Depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // Group size after reset
    localparam logic [4:0] GROUP_SIZE_RST = 5'd2;

    // Register index of group_size
    localparam logic REG_GROUP_SIZE = 1'b0;

    // Drain command: one held group, read out by the back end
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             eol;
    } t_cmd;

    // Bank release from the back end once its last word is read
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

endpackage

// File: rtl/grb_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module grb_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  grb_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    input  logic          i_pop,
    output grb_pkg::t_cmd o_pop_cmd,
    output logic          o_pop_valid
);

    grb_pkg::t_cmd r_slot [grb_pkg::Q_DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_push_ready = (r_count != 2'(grb_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'(grb_pkg::Q_DEPTH)) |-> !i_push)
        else $error("command pushed into full queue");
`endif

endmodule

// File: rtl/grb_front.sv
// Front end: accepts list values, writes them to the group banks, queues drain commands.
`timescale 1ns / 1ps

module grb_front #(
    parameter int MAX_GROUP = 16,
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [4:0]           i_group_size,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_value,
    input  logic                 i_eol,
    output logic                 o_wr_en,
    output logic [IW:0]          o_wr_addr,
    output logic [31:0]          o_wr_data,
    output logic                 o_push,
    output grb_pkg::t_cmd        o_push_cmd,
    input  logic                 i_push_ready,
    input  grb_pkg::t_rel        i_rel
);

    localparam int KW = $clog2(MAX_GROUP + 1);
    localparam int CW = (KW > 5) ? KW : 5;

    logic          r_bank;
    logic [KW-1:0] r_fill;
    logic [1:0]    r_busy;

    logic          accept;
    logic          fill_full;
    logic [KW-1:0] n_count;
    logic [CW-1:0] gs_x;
    logic [CW-1:0] k_eff;
    logic          group_done;
    logic [1:0]    n_busy;

    // Clamp group size into 1..MAX_GROUP
    always_comb begin
        gs_x = CW'(i_group_size);
        if (gs_x == '0) begin
            k_eff = CW'(1);
        end else if (gs_x > CW'(MAX_GROUP)) begin
            k_eff = CW'(MAX_GROUP);
        end else begin
            k_eff = gs_x;
        end
    end

    assign o_ready    = !r_busy[r_bank] && i_push_ready;
    assign accept     = i_valid && o_ready;
    assign fill_full  = (r_fill == KW'(MAX_GROUP));
    assign n_count    = fill_full ? r_fill : r_fill + KW'(1);
    assign group_done = (CW'(n_count) >= k_eff);

    // Write the value into the open bank
    assign o_wr_en   = accept && !fill_full;
    assign o_wr_addr = {r_bank, r_fill[IW-1:0]};
    assign o_wr_data = i_value;

    // Issue a drain command on a full group or end of list
    assign o_push           = accept && (group_done || i_eol);
    assign o_push_cmd.bank  = r_bank;
    assign o_push_cmd.count = grb_pkg::CNT_W'(n_count);
    assign o_push_cmd.rev   = group_done;
    assign o_push_cmd.eol   = i_eol;

    // Release a drained bank and claim the bank that just closed
    always_comb begin
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    // Track fill level, open bank and bank ownership
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_fill <= '0;
            r_busy <= 2'b00;
        end else begin
            r_busy <= n_busy;
            if (o_push) begin
                r_bank <= ~r_bank;
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= n_count;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < KW'(MAX_GROUP))
        else $error("held count reached the bank depth");
`endif

endmodule

// File: rtl/grb_back.sv
// Back end: group banks, drain sequencer and output register.
`timescale 1ns / 1ps

module grb_back #(
    parameter int MAX_GROUP = 16,
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [IW:0]   i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  grb_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    output grb_pkg::t_rel o_rel,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_value,
    output logic          o_last,
    output logic          o_done
);

    localparam int KW = $clog2(MAX_GROUP + 1);

    logic [31:0]   r_mem [2 << IW];

    grb_pkg::t_cmd r_cmd;
    logic          r_active;
    logic [KW-1:0] r_idx;

    logic          r_s1_valid;
    logic [31:0]   r_rd_data;
    logic          r_s1_last;
    logic          r_s1_done;

    logic          r_o_valid;
    logic [31:0]   r_o_value;
    logic          r_o_last;
    logic          r_o_done;

    logic [KW-1:0] cnt;
    logic [KW-1:0] rd_idx;
    logic          s1_move;
    logic          issue;
    logic          issue_last;

    assign cnt        = r_cmd.count[KW-1:0];
    assign s1_move    = r_s1_valid && (!r_o_valid || i_ready);
    assign issue      = r_active && (!r_s1_valid || s1_move);
    assign issue_last = issue && (r_idx + KW'(1) == cnt);
    assign o_cmd_pop  = i_cmd_valid && (!r_active || issue_last);
    assign rd_idx     = r_cmd.rev ? (cnt - KW'(1) - r_idx) : r_idx;

    // Free the bank once its last word is read
    assign o_rel.valid = issue_last;
    assign o_rel.bank  = r_cmd.bank;

    // Bank storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{r_cmd.bank, rd_idx[IW-1:0]}];
            r_s1_last <= issue_last;
            r_s1_done <= issue_last && r_cmd.eol;
        end
    end

    // Load commands and the output register
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (s1_move) begin
            r_o_value <= r_rd_data;
            r_o_last  <= r_s1_last;
            r_o_done  <= r_s1_done;
        end
    end

    // Step the drain index and the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (issue_last) begin
                r_active <= 1'b0;
            end else if (issue) begin
                r_idx <= r_idx + KW'(1);
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_value = r_o_value;
    assign o_last  = r_o_last;
    assign o_done  = r_o_done;

`ifndef NO_ASSERTIONS
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx < cnt))
        else $error("drain index ran past the group");
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_rd_data)))
        else $error("read stage lost a word while stalled");
`endif

endmodule

// File: rtl/group_reverse_buffer.sv
// A value that closes a group or ends the list queues a drain command for its group;
// the back end reads the group out through its read and output registers, one result
// per cycle while the output is ready. A bank is freed once its last word is read,
// and output stalls hold the front.
// Reset (synchronous, active low) empties the banks, the queue and the output,
// and sets group_size to 2; bank contents are not cleared.
`timescale 1ns / 1ps

module group_reverse_buffer #(
    parameter int MAX_GROUP = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tlast,   // end_of_list
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] out_value
    output logic        o_m_tlast,   // last_of_run
    output logic        o_m_tuser,   // [0] list_done
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic [4:0]    r_group_size;

    logic          wr_en;
    logic [IW:0]   wr_addr;
    logic [31:0]   wr_data;
    logic          push;
    logic          push_ready;
    grb_pkg::t_cmd push_cmd;
    grb_pkg::t_cmd pop_cmd;
    logic          pop;
    logic          pop_valid;
    grb_pkg::t_rel rel;

    // Register file
    assign pready = 1'b1;
    assign prdata = (paddr[2] == grb_pkg::REG_GROUP_SIZE) ? {27'd0, r_group_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= grb_pkg::GROUP_SIZE_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == grb_pkg::REG_GROUP_SIZE)) begin
            r_group_size <= pwdata[4:0];
        end
    end

    grb_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_size (r_group_size),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_value      (i_s_tdata),
        .i_eol        (i_s_tlast),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (push),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready),
        .i_rel        (rel)
    );

    grb_cmd_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_cmd    (pop_cmd),
        .o_pop_valid  (pop_valid)
    );

    grb_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_cmd       (pop_cmd),
        .i_cmd_valid (pop_valid),
        .o_cmd_pop   (pop),
        .o_rel       (rel),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_value     (o_m_tdata),
        .o_last      (o_m_tlast),
        .o_done      (o_m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("list end flagged on a word that does not close its run");
`endif

endmodule
